FILE: rtl/rlbd_pkg.sv
package rlbd_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MEDIAN,
		ST_DECODE,
		ST_UPDATE,
		ST_REPORT
	} state_t;

	localparam int BTN_W      = 7;
	localparam int SAMPLE_W   = 12;
	localparam int TIME_W     = 32;
	localparam int DEBOUNCE_W = 16;
	localparam int WIN_W      = 24;
	localparam int WIN_COUNT  = 5;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_1   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_2   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_3   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_1  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_2  = 3'd5;

	// window slots: left 0..2, right 3..4
	localparam logic [2:0] RIGHT_WIN_BASE = 3'd3;
	// raw mask layout
	localparam logic [2:0] RIGHT_BIT_BASE = 3'd4;
	localparam int         POWER_BIT      = 6;

	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 16'd50;
	localparam logic [WIN_W-1:0] WIN_RST [WIN_COUNT] = '{
		{12'd2048, 12'd600},
		{12'd1024, 12'd450},
		{12'd0,    12'd350},
		{12'd2048, 12'd600},
		{12'd0,    12'd350}
	};

	localparam logic [SAMPLE_W-1:0] EMPTY_READING = 12'hFFF;

endpackage

FILE: rtl/resistor_ladder_button_debouncer_unit.sv
// Resistor-ladder keypad debouncer. Sample transactions (tuser operation 0) store one
// 12-bit reading into the buffer of the named ladder; readings beyond SAMPLES per
// ladder are dropped. An evaluate transaction (operation 1) runs a sequencer over one
// shared rank unit (median search, one candidate per cycle) and one shared window
// comparator (one window per cycle): it starts, finds the median of each ladder, then
// decodes each ladder until a window matches or its last window is tried, then updates
// the debounce state and loads the result, waiting while a previous result still
// waits at the output. The input is not ready during an evaluation; one result
// transaction is produced per evaluate, none per sample, and a waiting result does
// not block new sample transactions.
module resistor_ladder_button_debouncer_unit
	import rlbd_pkg::*;
#(
	parameter int SAMPLES       = 5,
	parameter int LEFT_BUTTONS  = 3,
	parameter int RIGHT_BUTTONS = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [WIN_W-1:0]      cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [47:0]           s_tdata,  // sample[11:0], power_low, now_ms[31:0], pad
	input  logic [1:0]            s_tuser,  // operation, ladder
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [87:0]           m_tdata   // buttons_held, pressed_events,
	                                        // released_events, held_time_ms,
	                                        // power_held_time_ms, pad
);

	localparam int CW   = $clog2(SAMPLES + 1);
	localparam int IW   = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
	localparam int IDXW = (IW > 2) ? IW : 2;
	localparam logic [1:0] LAST_L = 2'(LEFT_BUTTONS - 1);
	localparam logic [1:0] LAST_R = 2'(RIGHT_BUTTONS - 1);

	state_t state_q, state_d;

	logic [DEBOUNCE_W-1:0] debounce_q;
	logic [WIN_W-1:0]      win_q [WIN_COUNT];

	logic [SAMPLE_W-1:0] left_buf_q  [SAMPLES];
	logic [SAMPLE_W-1:0] right_buf_q [SAMPLES];
	logic [CW-1:0]       left_fill_q, right_fill_q;
	logic [SAMPLE_W-1:0] med_q [2];

	logic            side_q;
	logic [IDXW-1:0] idx_q;
	logic [BTN_W-1:0] raw_q;
	logic            pwr_q;
	logic [TIME_W-1:0] now_q;

	logic [BTN_W-1:0]  last_raw_q, debounced_q, pressed_q, released_q;
	logic [TIME_W-1:0] change_time_q, press_start_q, press_finish_q;
	logic [TIME_W-1:0] power_start_q, power_finish_q;

	logic        m_tvalid_q;
	logic [87:0] m_tdata_q;

	// handshake
	logic s_acc, eval_acc, samp_acc, out_free, load_out;

	// median rank unit
	logic [CW-1:0]       cur_fill, lt_cnt, le_cnt, k_pos;
	logic [SAMPLE_W-1:0] cand, elem, med_val;
	logic                med_empty, med_done;

	// window comparator
	logic [2:0]          wsel, bitpos;
	logic [WIN_W-1:0]    win_sel;
	logic [SAMPLE_W-1:0] level, tol, cur_med, diff;
	logic                win_match, win_last;

	// debounce update
	logic [5:0]        btn, held;
	logic [BTN_W-1:0]  san, pr, rl;
	logic [TIME_W-1:0] elapsed;
	logic              take;

	// report
	logic [TIME_W-1:0] held_t, pwr_t;

	// ---------------- control outputs ----------------
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		s_acc    = s_tvalid && s_tready;
		eval_acc = s_acc && s_tuser[0];
		samp_acc = s_acc && !s_tuser[0];
		out_free = !m_tvalid_q || m_tready;
		load_out = (state_q == ST_REPORT) && out_free;
	end

	// ---------------- median candidate ----------------
	always_comb begin
		cur_fill = side_q ? right_fill_q : left_fill_q;
		cand     = side_q ? right_buf_q[idx_q[IW-1:0]] : left_buf_q[idx_q[IW-1:0]];
		lt_cnt   = '0;
		le_cnt   = '0;
		for (int j = 0; j < SAMPLES; j++) begin
			elem = side_q ? right_buf_q[j] : left_buf_q[j];
			if (CW'(j) < cur_fill) begin
				if (elem < cand)
					lt_cnt = lt_cnt + CW'(1);
				if (elem <= cand)
					le_cnt = le_cnt + CW'(1);
			end
		end
		k_pos     = cur_fill >> 1;
		med_empty = (cur_fill == '0);
		med_done  = med_empty || ((lt_cnt <= k_pos) && (k_pos < le_cnt));
		med_val   = med_empty ? EMPTY_READING : cand;
	end

	// ---------------- window compare ----------------
	always_comb begin
		wsel      = side_q ? (RIGHT_WIN_BASE + {1'b0, idx_q[1:0]}) : {1'b0, idx_q[1:0]};
		bitpos    = side_q ? (RIGHT_BIT_BASE + {1'b0, idx_q[1:0]}) : {1'b0, idx_q[1:0]};
		win_sel   = win_q[wsel];
		level     = win_sel[23:12];
		tol       = win_sel[11:0];
		cur_med   = med_q[side_q];
		diff      = (cur_med >= level) ? (cur_med - level) : (level - cur_med);
		win_match = (diff <= tol);
		win_last  = (idx_q[1:0] == (side_q ? LAST_R : LAST_L));
	end

	// ---------------- sanitize and debounce ----------------
	always_comb begin
		btn  = raw_q[5:0];
		held = debounced_q[5:0];
		if (btn == '0)
			san = {raw_q[POWER_BIT], 6'b0};
		else if ($onehot(held))
			san = {raw_q[POWER_BIT], held};
		else if ($onehot(btn))
			san = {raw_q[POWER_BIT], btn};
		else
			san = {raw_q[POWER_BIT], 6'b0};
		elapsed = now_q - change_time_q;
		take    = (san == last_raw_q) && (elapsed > {16'b0, debounce_q})
			&& (san != debounced_q);
		pr      = san & ~debounced_q;
		rl      = debounced_q & ~san;
	end

	always_comb begin
		held_t = ((debounced_q != '0) ? now_q : press_finish_q) - press_start_q;
		pwr_t  = (debounced_q[POWER_BIT] ? now_q : power_finish_q) - power_start_q;
	end

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (eval_acc)
					state_d = ST_MEDIAN;
			end
			ST_MEDIAN: begin
				if (med_done && side_q)
					state_d = ST_DECODE;
			end
			ST_DECODE: begin
				if ((win_match || win_last) && side_q)
					state_d = ST_UPDATE;
			end
			ST_UPDATE: state_d = ST_REPORT;
			ST_REPORT: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			debounce_q     <= DEBOUNCE_RST;
			win_q          <= WIN_RST;
			left_fill_q    <= '0;
			right_fill_q   <= '0;
			side_q         <= 1'b0;
			idx_q          <= '0;
			last_raw_q     <= '0;
			debounced_q    <= '0;
			change_time_q  <= '0;
			press_start_q  <= '0;
			press_finish_q <= '0;
			power_start_q  <= '0;
			power_finish_q <= '0;
			m_tvalid_q     <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				case (cfg_index)
					REG_DEBOUNCE: debounce_q <= cfg_data[DEBOUNCE_W-1:0];
					REG_LEFT_1:   win_q[0]   <= cfg_data;
					REG_LEFT_2:   win_q[1]   <= cfg_data;
					REG_LEFT_3:   win_q[2]   <= cfg_data;
					REG_RIGHT_1:  win_q[3]   <= cfg_data;
					REG_RIGHT_2:  win_q[4]   <= cfg_data;
					default: ;
				endcase
			end

			if (samp_acc) begin
				if (!s_tuser[1] && left_fill_q < CW'(SAMPLES))
					left_fill_q <= left_fill_q + CW'(1);
				if (s_tuser[1] && right_fill_q < CW'(SAMPLES))
					right_fill_q <= right_fill_q + CW'(1);
			end

			if (eval_acc) begin
				side_q <= 1'b0;
				idx_q  <= '0;
			end

			if (state_q == ST_MEDIAN) begin
				if (med_done) begin
					side_q <= ~side_q;
					idx_q  <= '0;
				end else begin
					idx_q <= idx_q + IDXW'(1);
				end
			end

			if (state_q == ST_DECODE) begin
				if (win_match || win_last) begin
					side_q <= ~side_q;
					idx_q  <= '0;
				end else begin
					idx_q <= idx_q + IDXW'(1);
				end
			end

			if (state_q == ST_UPDATE) begin
				left_fill_q  <= '0;
				right_fill_q <= '0;
				if (san != last_raw_q) begin
					change_time_q <= now_q;
					last_raw_q    <= san;
				end
				if (take) begin
					if (pr != '0 && debounced_q == '0)
						press_start_q <= now_q;
					if (rl != '0 && san == '0)
						press_finish_q <= now_q;
					if (pr[POWER_BIT])
						power_start_q <= now_q;
					if (rl[POWER_BIT])
						power_finish_q <= now_q;
					debounced_q <= san;
				end
			end

			if (load_out)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		if (samp_acc) begin
			if (!s_tuser[1] && left_fill_q < CW'(SAMPLES))
				left_buf_q[left_fill_q[IW-1:0]] <= s_tdata[11:0];
			if (s_tuser[1] && right_fill_q < CW'(SAMPLES))
				right_buf_q[right_fill_q[IW-1:0]] <= s_tdata[11:0];
		end
		if (eval_acc) begin
			raw_q <= '0;
			pwr_q <= s_tdata[12];
			now_q <= s_tdata[44:13];
		end
		if (state_q == ST_MEDIAN && med_done)
			med_q[side_q] <= med_val;
		if (state_q == ST_DECODE) begin
			if (win_match)
				raw_q[bitpos] <= 1'b1;
			if (win_last || win_match)
				raw_q[POWER_BIT] <= pwr_q;
		end
		if (state_q == ST_UPDATE) begin
			pressed_q  <= take ? pr : '0;
			released_q <= take ? rl : '0;
		end
		if (load_out)
			m_tdata_q <= {3'b0, pwr_t, held_t, released_q, pressed_q, debounced_q};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
